// ===== hw/rtl/kcs_pkg.sv =====
// ============================================================================
// kcs_pkg
// Shared constants, codes and types of the k-combination successor.
// ============================================================================
`default_nettype none

package kcs_pkg;

    // Largest subset size and largest set size the block supports.
    localparam int MAX_K = 8;
    localparam int MAX_N = 64;

    // Configuration register widths, fixed by the register map.
    localparam int N_W   = 7;
    localparam int K_W   = 4;
    localparam int CFG_W = 7;
    localparam int CFG_IDX_W = 1;

    // Derived widths.
    localparam int POS_W  = (MAX_N > 2) ? $clog2(MAX_N) : 1;
    localparam int SLOT_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KIDX_W = SLOT_W;
    localparam int KCNT_W = $clog2(MAX_K + 1);
    localparam int LIM_W  = N_W + 1;
    localparam int STAT_W = 2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSET_SIZE = 1'd1;

    // Status codes.
    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_DONE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_KGTN = 2'd2;

    // Output sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_ERROR
    } kcs_state_t;

    // Per-cycle controls broadcast to every cell.
    typedef struct packed {
        logic clear;    // configuration write: back to ascending
        logic load;     // request accepted: commit and load shift stage
        logic restart;  // accepted request asks for the first combination
        logic advance;  // accepted request moves to the successor
        logic shift;    // one word taken: shift toward cell 0
    } kcs_cell_ctl_t;

    // Start command from the datapath to the sequencer.
    typedef struct packed {
        logic              start;
        logic              is_err;
        logic [STAT_W-1:0] err_code;
    } kcs_cmd_t;

    // Sequencer status back to the datapath.
    typedef struct packed {
        logic busy;
        logic in_error;
        logic shift;
    } kcs_seq_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kcs_cell.sv =====
// ============================================================================
// kcs_cell
// One slot of the combination: holds its position and a shift stage.
// ============================================================================
`default_nettype none

module kcs_cell
    import kcs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [KIDX_W-1:0]    idx,
    input  wire logic [KCNT_W-1:0]    eff_k,
    input  wire logic [N_W-1:0]       nk,
    input  wire kcs_cell_ctl_t        ctl,
    input  wire logic                 found_in,
    output logic                      found_out,
    input  wire logic                 after_in,
    input  wire logic [POS_W-1:0]     val_in,
    output logic                      after_out,
    output logic [POS_W-1:0]          val_out,
    output logic [POS_W-1:0]          cur_out,
    input  wire logic [POS_W-1:0]     shift_in,
    output logic [POS_W-1:0]          shift_out
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] shift_reg;
    logic [POS_W-1:0] shift_next;
    logic [POS_W-1:0] pos_eff;
    logic [POS_W-1:0] new_val;
    logic [LIM_W-1:0] limit;
    logic             active;
    logic             below;
    logic             pivot_here;

    always_comb
    begin
        pos_eff    = ctl.restart ? POS_W'(idx) : pos_reg;
        active     = (KCNT_W'(idx) < eff_k);
        limit      = LIM_W'(nk) + LIM_W'(idx);
        below      = active && (LIM_W'(pos_eff) < limit);
        pivot_here = below && !found_in;
        found_out  = found_in || below;
        if (pivot_here)
        begin
            new_val = pos_eff + POS_W'(1);
        end
        else if (after_in)
        begin
            new_val = val_in + POS_W'(1);
        end
        else
        begin
            new_val = pos_eff;
        end
        after_out = after_in || pivot_here;
        val_out   = new_val;
        cur_out   = ctl.advance ? new_val : pos_eff;
    end

    always_comb
    begin
        pos_next   = pos_reg;
        shift_next = shift_reg;
        if (ctl.clear)
        begin
            pos_next = POS_W'(idx);
        end
        else if (ctl.load)
        begin
            pos_next = cur_out;
        end
        if (ctl.load)
        begin
            shift_next = cur_out;
        end
        else if (ctl.shift)
        begin
            shift_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_W'(idx);
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign shift_out = shift_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/kcs_ctrl.sv =====
// ============================================================================
// kcs_ctrl
// Output sequencer: walks the slots of a combination or sends one error word.
// ============================================================================
`default_nettype none

module kcs_ctrl
    import kcs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire kcs_cmd_t             cmd,
    input  wire logic [SLOT_W-1:0]    k_last,
    input  wire logic                 res_stall,
    output logic                      res_valid,
    output logic [SLOT_W-1:0]         slot,
    output logic                      last_of_run,
    output logic [STAT_W-1:0]         status,
    output kcs_seq_t                  seq
);

    kcs_state_t        state_reg;
    kcs_state_t        state_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [STAT_W-1:0] code_reg;
    logic [STAT_W-1:0] code_next;
    logic              at_last;

    assign at_last = (slot_reg == k_last);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        code_next  = code_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    slot_next  = '0;
                    code_next  = cmd.err_code;
                    state_next = cmd.is_err ? ST_ERROR : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!res_stall)
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                    if (at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERROR:
            begin
                if (!res_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        res_valid    = 1'b0;
        slot         = '0;
        last_of_run  = 1'b0;
        status       = STATUS_OK;
        seq.busy     = 1'b1;
        seq.in_error = 1'b0;
        seq.shift    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                seq.busy = 1'b0;
            end
            ST_EMIT:
            begin
                res_valid   = 1'b1;
                slot        = slot_reg;
                last_of_run = at_last;
                seq.shift   = !res_stall;
            end
            ST_ERROR:
            begin
                res_valid    = 1'b1;
                last_of_run  = 1'b1;
                status       = code_reg;
                seq.in_error = 1'b1;
            end
            default:
            begin
                seq.busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            code_reg  <= STATUS_OK;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            code_reg  <= code_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/k_combination_successor.sv =====
// ============================================================================
// k_combination_successor
// Lexicographic enumerator of the K-element subsets of {0..N-1}.
// ============================================================================
//
//  Channel   Handshake              Payload
//  -------   --------------------   ------------------------------------------
//  request   req_valid / req_stall  restart
//  result    res_valid / res_stall  slot, element_value, last_of_run,
//                                   final_combination, status
//  config    cfg_we                 cfg_index, cfg_data
//
//  When a request word is taken, the successor is formed in the same cycle
//  by the row of cells; the combination then leaves as K result words, one
//  per cycle while res_stall is low, shifted out of the cells toward cell 0.
//  An error answer is a single result word.
//  Reset restores N = 8, K = 3 and the first combination.
//  A stalled result word holds; no request is taken until the last word of
//  the current answer has been taken.
//
`default_nettype none

module k_combination_successor
    import kcs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Request channel.
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire logic                 restart,
    // Result channel.
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output logic [SLOT_W-1:0]         slot,
    output logic [POS_W-1:0]          element_value,
    output logic                      last_of_run,
    output logic                      final_combination,
    output logic [STAT_W-1:0]         status,
    // Configuration port.
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // Configuration registers and enumeration flags.
    logic [N_W-1:0]    set_size_reg;
    logic [N_W-1:0]    set_size_next;
    logic [K_W-1:0]    subset_size_reg;
    logic [K_W-1:0]    subset_size_next;
    logic              started_reg;
    logic              started_next;
    logic              exhausted_reg;
    logic              exhausted_next;
    logic              final_reg;
    logic              final_next;

    logic [KCNT_W-1:0] eff_k;
    logic [N_W-1:0]    eff_n;
    logic [N_W-1:0]    nk;
    logic              k_gt_n;
    logic              req_accept;
    logic              started_eff;
    logic              exhausted_eff;
    logic              path_ok;
    logic              advance;
    logic              is_final;

    kcs_cell_ctl_t     cell_ctl;
    kcs_cmd_t          cmd;
    kcs_seq_t          seq;

    // Neighbor chains through the row of cells.
    logic              found_w [MAX_K+1];
    logic              after_w [MAX_K+1];
    logic [POS_W-1:0]  val_w   [MAX_K+1];
    logic [POS_W-1:0]  shift_w [MAX_K+1];
    logic [POS_W-1:0]  cur_w   [MAX_K];

    // Out-of-range sizes are clamped: K to 1..MAX_K, N to at most MAX_N.
    always_comb
    begin
        if (subset_size_reg == '0)
        begin
            eff_k = KCNT_W'(1);
        end
        else if (int'(subset_size_reg) > MAX_K)
        begin
            eff_k = KCNT_W'(MAX_K);
        end
        else
        begin
            eff_k = KCNT_W'(subset_size_reg);
        end
        if (int'(set_size_reg) > MAX_N)
        begin
            eff_n = N_W'(MAX_N);
        end
        else
        begin
            eff_n = set_size_reg;
        end
        k_gt_n = (int'(eff_k) > int'(eff_n));
        nk     = eff_n - N_W'(eff_k);
    end

    assign req_stall  = seq.busy;
    assign req_accept = req_valid && !req_stall;

    // A restart on the request takes effect before the request is served.
    assign started_eff   = started_reg && !restart;
    assign exhausted_eff = exhausted_reg && !restart;

    // The cells tell whether any slot can still move; the first request
    // after a restart emits the ascending combination as it stands.
    always_comb
    begin
        path_ok      = 1'b0;
        advance      = 1'b0;
        cmd.start    = req_accept;
        cmd.is_err   = 1'b1;
        cmd.err_code = STATUS_DONE;
        if (k_gt_n)
        begin
            cmd.err_code = STATUS_KGTN;
        end
        else if (exhausted_eff)
        begin
            cmd.err_code = STATUS_DONE;
        end
        else if (!started_eff)
        begin
            path_ok    = 1'b1;
            cmd.is_err = 1'b0;
        end
        else if (found_w[0])
        begin
            path_ok    = 1'b1;
            advance    = 1'b1;
            cmd.is_err = 1'b0;
        end
        else
        begin
            cmd.err_code = STATUS_DONE;
        end
    end

    // The combination is the last one when slot 0 sits at N - K.
    assign is_final = (N_W'(cur_w[0]) == nk);

    always_comb
    begin
        cell_ctl.clear   = cfg_we;
        cell_ctl.load    = req_accept;
        cell_ctl.restart = restart;
        cell_ctl.advance = req_accept && path_ok && advance;
        cell_ctl.shift   = seq.shift;
    end

    always_comb
    begin
        set_size_next    = set_size_reg;
        subset_size_next = subset_size_reg;
        started_next     = started_reg;
        exhausted_next   = exhausted_reg;
        final_next       = final_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SET_SIZE:
                begin
                    set_size_next = cfg_data[N_W-1:0];
                end
                REG_SUBSET_SIZE:
                begin
                    subset_size_next = cfg_data[K_W-1:0];
                end
                default:
                begin
                    set_size_next = set_size_reg;
                end
            endcase
            started_next   = 1'b0;
            exhausted_next = 1'b0;
        end
        else if (req_accept)
        begin
            if (k_gt_n)
            begin
                started_next   = started_eff;
                exhausted_next = exhausted_eff;
            end
            else if (path_ok)
            begin
                started_next   = 1'b1;
                exhausted_next = is_final;
                final_next     = is_final;
            end
            else
            begin
                // Already exhausted, or no slot below its maximum.
                started_next   = started_eff;
                exhausted_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg    <= N_W'(8);
            subset_size_reg <= K_W'(3);
            started_reg     <= 1'b0;
            exhausted_reg   <= 1'b0;
            final_reg       <= 1'b0;
        end
        else
        begin
            set_size_reg    <= set_size_next;
            subset_size_reg <= subset_size_next;
            started_reg     <= started_next;
            exhausted_reg   <= exhausted_next;
            final_reg       <= final_next;
        end
    end

    // Chain ends: the pivot search enters at the right, the refill at the
    // left, and zeros fill in behind the shifted-out words.
    assign found_w[MAX_K] = 1'b0;
    assign after_w[0]     = 1'b0;
    assign val_w[0]       = '0;
    assign shift_w[MAX_K] = '0;

    for (genvar i = 0; i < MAX_K; i++)
    begin : g_cell
        kcs_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (KIDX_W'(i)),
            .eff_k     (eff_k),
            .nk        (nk),
            .ctl       (cell_ctl),
            .found_in  (found_w[i+1]),
            .found_out (found_w[i]),
            .after_in  (after_w[i]),
            .val_in    (val_w[i]),
            .after_out (after_w[i+1]),
            .val_out   (val_w[i+1]),
            .cur_out   (cur_w[i]),
            .shift_in  (shift_w[i+1]),
            .shift_out (shift_w[i])
        );
    end

    kcs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .k_last      (SLOT_W'(eff_k - KCNT_W'(1))),
        .res_stall   (res_stall),
        .res_valid   (res_valid),
        .slot        (slot),
        .last_of_run (last_of_run),
        .status      (status),
        .seq         (seq)
    );

    // Error words carry zero value and no final flag.
    assign element_value     = seq.in_error ? '0 : shift_w[0];
    assign final_combination = seq.in_error ? 1'b0 : final_reg;

endmodule

`default_nettype wire
